>>> rtl/fdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, character codes and classifier functions for the format
// directive checker.
// ----------------------------------------------------------------------------
package fdc_pkg;

   localparam int CHAR_BITS_DEF = 16;
   localparam int CHAR_MAX_BITS = 32;

   localparam logic [CHAR_MAX_BITS-1:0] CH_PERCENT = 32'h25;
   localparam logic [CHAR_MAX_BITS-1:0] CH_STAR    = 32'h2A;
   localparam logic [CHAR_MAX_BITS-1:0] CH_DOT     = 32'h2E;
   localparam logic [CHAR_MAX_BITS-1:0] CH_PLUS    = 32'h2B;
   localparam logic [CHAR_MAX_BITS-1:0] CH_MINUS   = 32'h2D;
   localparam logic [CHAR_MAX_BITS-1:0] CH_HASH    = 32'h23;
   localparam logic [CHAR_MAX_BITS-1:0] CH_SPACE   = 32'h20;
   localparam logic [CHAR_MAX_BITS-1:0] CH_ZERO    = 32'h30;
   localparam logic [CHAR_MAX_BITS-1:0] CH_NINE    = 32'h39;
   localparam logic [CHAR_MAX_BITS-1:0] CH_UPPER_S = 32'h53;

   // integer precision longer than this many digits is unsafe
   localparam logic [1:0] PREC_LIMIT = 2'd2;
   localparam logic [1:0] PREC_SAT   = 2'd3;

   typedef enum logic [6:0] {
      PH_BEFORE = 7'b0000001,
      PH_FLAGS  = 7'b0000010,
      PH_WIDTH  = 7'b0000100,
      PH_PREC   = 7'b0001000,
      PH_SPEC   = 7'b0010000,
      PH_AFTER  = 7'b0100000,
      PH_REJECT = 7'b1000000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_INT    = 2'd1,
      KIND_DOUBLE = 2'd2,
      KIND_STRING = 2'd3
   } kind_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] prec_count;
      kind_type   kind;
   } parse_stat_type;

   function automatic logic is_digit(input logic [CHAR_MAX_BITS-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_flag(input logic [CHAR_MAX_BITS-1:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_HASH) || (c == CH_SPACE);
   endfunction

   function automatic kind_type spec_kind(input logic [CHAR_MAX_BITS-1:0] c);
      kind_type k;
      case (c)
         32'h63, 32'h43, 32'h64, 32'h69,
         32'h6F, 32'h75, 32'h78, 32'h58: k = KIND_INT;
         32'h65, 32'h45, 32'h66, 32'h67,
         32'h47:                         k = KIND_DOUBLE;
         32'h73, 32'h53:                 k = KIND_STRING;
         default:                        k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

>>> rtl/fdc_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_parse
// Directive phase tracker: holds the per-string state and resolves one
// character, including phase fall-through, in a single pass.
// ----------------------------------------------------------------------------
module fdc_parse #(
   parameter int CHAR_BITS = fdc_pkg::CHAR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_valid,
   input  logic [CHAR_BITS-1:0]   char_code,
   input  logic                   last_char,
   output logic [CHAR_BITS-1:0]   out_char,
   output fdc_pkg::kind_type      verdict,
   output fdc_pkg::parse_stat_type stat
);
   import fdc_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [1:0] prec_ff, prec_in;
   kind_type   kind_ff, kind_in;

   logic [CHAR_MAX_BITS-1:0] c;
   logic       ch_pct, ch_star, ch_dot, ch_dig, ch_flag;
   kind_type   ch_kind;
   phase_type  ph_a, ph_b, ph_c;

   assign c       = CHAR_MAX_BITS'(char_code);
   assign ch_pct  = (c == CH_PERCENT);
   assign ch_star = (c == CH_STAR);
   assign ch_dot  = (c == CH_DOT);
   assign ch_dig  = is_digit(c);
   assign ch_flag = is_flag(c);
   assign ch_kind = spec_kind(c);

   // phase fall-through: flags -> width -> spec, precision -> spec
   assign ph_a = (phase_ff == PH_FLAGS && !ch_flag) ? PH_WIDTH : phase_ff;
   assign ph_b = (ph_a == PH_WIDTH && !ch_star && !ch_dig && !ch_dot) ? PH_SPEC : ph_a;
   assign ph_c = (ph_b == PH_PREC && !ch_star && !ch_dig) ? PH_SPEC : ph_b;

   always_comb begin
      phase_in = ph_c;
      prec_in  = prec_ff;
      kind_in  = kind_ff;
      out_char = char_code;
      case (ph_c)
         PH_BEFORE: begin
            if (ch_pct) phase_in = PH_FLAGS;
         end
         PH_FLAGS: begin
            phase_in = PH_FLAGS;
         end
         PH_WIDTH: begin
            if (ch_star)     phase_in = PH_REJECT;
            else if (ch_dot) phase_in = PH_PREC;
         end
         PH_PREC: begin
            if (ch_star) phase_in = PH_REJECT;
            else if (prec_ff != PREC_SAT) prec_in = prec_ff + 2'd1;
         end
         PH_SPEC: begin
            if (ch_kind == KIND_NONE) begin
               phase_in = PH_REJECT;
            end else begin
               phase_in = PH_AFTER;
               kind_in  = ch_kind;
               if (ch_kind == KIND_STRING) out_char = CHAR_BITS'(CH_UPPER_S);
            end
         end
         PH_AFTER: begin
            if (ch_pct) phase_in = PH_REJECT;
         end
         PH_REJECT: begin
            phase_in = PH_REJECT;
         end
         default: begin
            phase_in = PH_REJECT;
         end
      endcase
   end

   always_comb begin
      verdict = KIND_NONE;
      if (last_char && phase_in != PH_REJECT &&
          !(kind_in == KIND_INT && prec_in > PREC_LIMIT)) begin
         verdict = kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BEFORE;
         prec_ff  <= '0;
         kind_ff  <= KIND_NONE;
      end else if (step_valid) begin
         if (last_char) begin
            phase_ff <= PH_BEFORE;
            prec_ff  <= '0;
            kind_ff  <= KIND_NONE;
         end else begin
            phase_ff <= phase_in;
            prec_ff  <= prec_in;
            kind_ff  <= kind_in;
         end
      end
   end

   assign stat.phase      = phase_ff;
   assign stat.prec_count = prec_ff;
   assign stat.kind       = kind_ff;

endmodule

>>> rtl/format_directive_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_directive_checker_top
// Streams a format string one character per beat, echoes each character and
// gives a safety verdict for the single directive on the last beat.
// ----------------------------------------------------------------------------
// One character is taken every cycle while the result side keeps up; after
// it is accepted each beat passes one input register, then the phase logic
// into the result register. The per-string state update is one pass of short
// compare logic, so throughput is one character per clock while rsp keeps up.
// The verdict on rsp_tuser is meaningful on the rsp_tlast beat and reads zero
// on all other beats. State returns to its reset value after each last beat.
module format_directive_checker_top #(
   parameter int CHAR_BITS = fdc_pkg::CHAR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((CHAR_BITS+7)/8)*8-1:0]    req_tdata,  // char_code
   input  logic                              req_tlast,  // last_char
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((CHAR_BITS+7)/8)*8-1:0]    rsp_tdata,  // out_char
   output logic                              rsp_tlast,  // is_final
   output logic [1:0]                        rsp_tuser   // verdict
);
   import fdc_pkg::*;

   localparam int DATA_BITS = ((CHAR_BITS + 7) / 8) * 8;

   logic                 in_valid_ff;
   logic [CHAR_BITS-1:0] in_char_ff;
   logic                 in_last_ff;
   logic                 rsp_valid_ff;
   logic [CHAR_BITS-1:0] rsp_char_ff;
   logic                 rsp_last_ff;
   kind_type             rsp_verdict_ff;

   logic                 advance;
   logic [CHAR_BITS-1:0] step_char;
   kind_type             step_verdict;
   parse_stat_type       stat;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   fdc_parse #(
      .CHAR_BITS(CHAR_BITS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .char_code  (in_char_ff),
      .last_char  (in_last_ff),
      .out_char   (step_char),
      .verdict    (step_verdict),
      .stat       (stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata[CHAR_BITS-1:0];
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         rsp_char_ff    <= step_char;
         rsp_last_ff    <= in_last_ff;
         rsp_verdict_ff <= step_verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(rsp_char_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_verdict_ff;

`ifndef NO_ASSERTIONS
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(stat.phase))
      else $error("phase state is not one-hot");

   a_string_restart: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> stat.phase == PH_BEFORE && stat.kind == KIND_NONE &&
                                stat.prec_count == 2'd0)
      else $error("state not cleared after last character");

   a_verdict_only_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == KIND_NONE)
      else $error("verdict set on a non-final beat");

   a_kind_after_spec: assert property (@(posedge clock) disable iff (reset)
      stat.kind != KIND_NONE |-> stat.phase == PH_AFTER || stat.phase == PH_REJECT)
      else $error("argument kind recorded before a specifier");
`endif

endmodule

>>> sim/tb_format_directive_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_format_directive_checker_top
// Streams format strings into the directive checker and compares every echoed
// beat and the end-of-string verdict against a cycle-free predictor of the
// directive phases. Directed strings first, then mostly well-formed random
// directives with random text around them, plus noise strings.
// ----------------------------------------------------------------------------
module tb_format_directive_checker_top;
   import fdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 200;

   typedef struct packed {
      logic [15:0] out_char;
      logic        is_final;
      logic [1:0]  verdict;
   } echo_beat_type;

   // predicts the echo and verdict per character and checks result beats
   class fmt_echo_scoreboard;
      phase_type     phase;
      logic [1:0]    prec_count;
      kind_type      kind;
      echo_beat_type echo_q[$];
      int            mismatches;

      function new();
         mismatches = 0;
         clear_string();
      endfunction

      function void clear_string();
         phase      = PH_BEFORE;
         prec_count = 2'd0;
         kind       = KIND_NONE;
      endfunction

      function int pending();
         return echo_q.size();
      endfunction

      function kind_type letter_kind(logic [15:0] c);
         kind_type k;
         case (c)
            "c", "C", "d", "i", "o", "u", "x", "X": k = KIND_INT;
            "e", "E", "f", "g", "G":                k = KIND_DOUBLE;
            "s", "S":                               k = KIND_STRING;
            default:                                k = KIND_NONE;
         endcase
         return k;
      endfunction

      function void note_char(logic [15:0] c, logic last);
         echo_beat_type e;
         logic          again;
         int            guard;
         kind_type      k;
         logic          digit;
         e.out_char = c;
         e.is_final = last;
         e.verdict  = 2'd0;
         digit = (c >= CH_ZERO) && (c <= CH_NINE);
         again = 1'b1;
         guard = 0;
         // a character that closes a phase is looked at again by the next one
         while (again && guard < 4) begin
            again = 1'b0;
            guard++;
            case (phase)
               PH_BEFORE: begin
                  if (c == CH_PERCENT) phase = PH_FLAGS;
               end
               PH_FLAGS: begin
                  if (!(c == CH_PLUS || c == CH_MINUS || c == CH_HASH || c == CH_SPACE)) begin
                     phase = PH_WIDTH;
                     again = 1'b1;
                  end
               end
               PH_WIDTH: begin
                  if (c == CH_STAR) begin
                     phase = PH_REJECT;
                  end else if (c == CH_DOT) begin
                     phase = PH_PREC;
                  end else if (!digit) begin
                     phase = PH_SPEC;
                     again = 1'b1;
                  end
               end
               PH_PREC: begin
                  if (c == CH_STAR) begin
                     phase = PH_REJECT;
                  end else if (digit) begin
                     if (prec_count != PREC_SAT) prec_count = prec_count + 2'd1;
                  end else begin
                     phase = PH_SPEC;
                     again = 1'b1;
                  end
               end
               PH_SPEC: begin
                  k = letter_kind(c);
                  if (k == KIND_NONE) begin
                     phase = PH_REJECT;
                  end else begin
                     kind = k;
                     if (k == KIND_STRING) e.out_char = CH_UPPER_S[15:0];
                     phase = PH_AFTER;
                  end
               end
               PH_AFTER: begin
                  if (c == CH_PERCENT) phase = PH_REJECT;
               end
               default: begin
                  phase = PH_REJECT;
               end
            endcase
         end
         if (last) begin
            if (phase == PH_REJECT) begin
               e.verdict = KIND_NONE;
            end else if (kind == KIND_INT && prec_count > PREC_LIMIT) begin
               e.verdict = KIND_NONE;
            end else begin
               e.verdict = kind;
            end
            clear_string();
         end
         echo_q = {echo_q, e};
      endfunction

      function void check_echo(logic [15:0] d, logic fin, logic [1:0] v);
         echo_beat_type e;
         if (echo_q.size() == 0) begin
            $error("result beat with nothing expected: out_char=%h is_final=%b verdict=%0d",
                   d, fin, v);
            mismatches++;
            return;
         end
         e = echo_q.pop_front();
         if (d !== e.out_char) begin
            $error("out_char: expected %h, actual %h", e.out_char, d);
            mismatches++;
         end
         if (fin !== e.is_final) begin
            $error("is_final: expected %b, actual %b", e.is_final, fin);
            mismatches++;
         end
         if (v !== e.verdict) begin
            $error("verdict: expected %0d, actual %0d", e.verdict, v);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // char_code
   logic        req_tlast;   // last_char
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // out_char
   logic        rsp_tlast;   // is_final
   logic [1:0]  rsp_tuser;   // verdict

   fmt_echo_scoreboard sb = new();
   bit idling        = 1'b1;
   bit long_hold_req = 1'b0;
   int chars_sent    = 0;

   format_directive_checker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_beat(input logic [15:0] c, input logic last);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_char(c, last);
      chars_sent++;
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++) send_beat({8'h00, s[i]}, i == s.len() - 1);
   endtask

   // random text that never opens a directive by itself
   function automatic logic [15:0] rand_text();
      logic [15:0] c;
      if ($urandom_range(0, 1) == 1) c = 16'($urandom_range(16'h20, 16'h7E));
      else c = 16'($urandom_range(0, 16'hFFFF));
      if (c == CH_PERCENT) c = CH_PERCENT[15:0] + 16'd1;
      return c;
   endfunction

   task automatic send_random_string();
      logic [15:0] str_q[$];
      string       flag_chars;
      string       spec_letters;
      flag_chars   = " +-#";
      spec_letters = "cCdiouxXeEfgGsS";
      if ($urandom_range(0, 9) == 0) begin
         // noise: raw wide characters with a few directive characters mixed in
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
               0:       str_q = {str_q, CH_PERCENT[15:0]};
               1:       str_q = {str_q, CH_DOT[15:0]};
               default: str_q = {str_q, 16'($urandom_range(0, 16'hFFFF))};
            endcase
         end
      end else begin
         repeat ($urandom_range(0, 4)) str_q = {str_q, rand_text()};
         if ($urandom_range(0, 9) != 0) str_q = {str_q, CH_PERCENT[15:0]};
         repeat ($urandom_range(0, 3))
            str_q = {str_q, {8'h00, flag_chars[$urandom_range(0, 3)]}};
         if ($urandom_range(0, 19) == 0) str_q = {str_q, CH_STAR[15:0]};
         repeat ($urandom_range(0, 2))
            str_q = {str_q, CH_ZERO[15:0] + 16'($urandom_range(0, 9))};
         if ($urandom_range(0, 1) == 1) begin
            str_q = {str_q, CH_DOT[15:0]};
            if ($urandom_range(0, 19) == 0) str_q = {str_q, CH_STAR[15:0]};
            repeat ($urandom_range(0, 4))
               str_q = {str_q, CH_ZERO[15:0] + 16'($urandom_range(0, 9))};
         end
         if ($urandom_range(0, 9) != 0)
            str_q = {str_q, {8'h00, spec_letters[$urandom_range(0, 14)]}};
         else str_q = {str_q, rand_text()};
         repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 9) == 0) str_q = {str_q, CH_PERCENT[15:0]};
            else str_q = {str_q, rand_text()};
         end
      end
      if (str_q.size() == 0) str_q = {str_q, rand_text()};
      foreach (str_q[i]) send_beat(str_q[i], i == str_q.size() - 1);
   endtask

   // result side: checks every beat, stalls in short bursts or one long hold
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_echo(rsp_tdata, rsp_tlast, rsp_tuser);
         if (long_hold_req) begin
            long_hold_req <= 1'b0;
            hold_left = LONG_HOLD;
         end else if (hold_left == 0 && idling && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 3);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // flags, width, precision and a string specifier echoed as S
      send_str("%-# +3.45s");
      // integer with too many precision digits
      send_str("%.123d");
      // star in width, second percent after the specifier, unknown specifier
      send_str("%*d");
      send_str("%e%");
      send_str("%q");
      // no percent sign at all, extreme character codes
      send_beat(16'h0000, 1'b0);
      send_beat(16'hFFFF, 1'b1);
      // directive cut off before its specifier
      send_str("%");

      while (chars_sent < 500) send_random_string();
      // hold the result side off while beats keep coming so the block backs up
      long_hold_req <= 1'b1;
      while (chars_sent < 700) send_random_string();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);
      while (chars_sent < 1200) send_random_string();
      idling = 1'b0;
      while (chars_sent < 1500) send_random_string();
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) $error("%0d expected result beats never arrived", sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
